// File: rtl/pvg_pkg.sv
// ----------------------------------------------------------------------------
// pvg_pkg
// Shared types and constants of the polygon vertex generator: payload
// structs, controller/datapath command and status, angle and CORDIC constants.
// ----------------------------------------------------------------------------
package pvg_pkg;

	// Field widths
	localparam int BOX_W   = 16;
	localparam int SIDES_W = 6;
	localparam int COORD_W = 24;

	// Coordinate limits
	localparam int unsigned COORD_POS_LIM = 8388607;
	localparam logic signed [COORD_W-1:0] COORD_MAX_V = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN_V = 24'sh800000;

	// Angles in hundredths of a degree
	localparam int ANGLE_W = 16;
	localparam logic [ANGLE_W-1:0] QUARTER_TURN       = 16'd9000;
	localparam logic [ANGLE_W-1:0] HALF_TURN          = 16'd18000;
	localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 16'd27000;
	localparam logic [ANGLE_W-1:0] FULL_TURN          = 16'd36000;

	// Shared divider
	localparam int DIV_NUM_W = 23;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
	localparam int RATIO_W   = DIV_NUM_W;
	localparam int RATIO_SCALE = 100;
	localparam int RATIO_HALF  = 50;

	// Digit-serial divide by 25 (after a shift by two for the factor four)
	localparam int DIGIT_W     = 8;
	localparam int DREM_W      = 5;
	localparam int DCUR_W      = DREM_W + DIGIT_W;
	localparam int DPROD_W     = 2 * DCUR_W;
	localparam int DIV25       = 25;
	localparam int RECIP_25    = 5243;
	localparam int RECIP_SHIFT = 17;

	// CORDIC, Q1.30, angle unit 1/25600 degree
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_IDX_W = $clog2(CORDIC_STEPS);
	localparam int CS_W         = 32;
	localparam int CS_MAG_W     = CS_W - 1;
	localparam int CORDIC_Z_W   = 25;
	localparam int ANGLE_FRAC   = 8;
	localparam int Q30_SHIFT    = 30;
	localparam logic signed [CS_W-1:0] CORDIC_GAIN = 32'sd652032874;

	localparam logic signed [CORDIC_Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		25'sd1152000, 25'sd680065, 25'sd359328, 25'sd182400,
		25'sd91554,   25'sd45822,  25'sd22916,  25'sd11459,
		25'sd5730,    25'sd2865,   25'sd1432,   25'sd716,
		25'sd358,     25'sd179,    25'sd90,     25'sd45
	};

	typedef struct packed {
		logic [BOX_W-1:0]   box_width;
		logic [BOX_W-1:0]   box_height;
		logic [SIDES_W-1:0] sides;
	} pvg_req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_pos;
		logic signed [COORD_W-1:0] y_pos;
		logic                      last;
	} pvg_vtx_t;

	typedef enum logic [1:0] {
		EMIT_NONE  = 2'd0,
		EMIT_START = 2'd1,
		EMIT_VTX   = 2'd2,
		EMIT_LAST  = 2'd3
	} pvg_emit_t;

	typedef struct packed {
		logic      accept;
		logic      ratio_take;
		logic      step_take;
		logic      angle_adv;
		logic      mul_r;
		logic      round_q30;
		logic      mul_a;
		logic      d100_load;
		pvg_emit_t emit;
	} pvg_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic rot_busy;
		logic d100_busy;
		logic out_free;
		logic more;
	} pvg_stat_t;

endpackage

// File: rtl/pvg_stream_if.sv
// ----------------------------------------------------------------------------
// pvg_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface pvg_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: rtl/pvg_divider.sv
// ----------------------------------------------------------------------------
// pvg_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pvg_divider import pvg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 busy,
	output logic [DIV_NUM_W-1:0] quo
);
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;
	logic [DIV_DEN_W-1:0] rem_nxt;

	assign trial   = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff    = trial - {1'b0, den_q};
	assign ge      = trial >= {1'b0, den_q};
	assign rem_nxt = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = quo_q;
endmodule

// File: rtl/pvg_cordic.sv
// ----------------------------------------------------------------------------
// pvg_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, with
// quadrant folding; returns sine and cosine as sign and magnitude.
// ----------------------------------------------------------------------------
module pvg_cordic import pvg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [ANGLE_W-1:0]  angle,
	output logic                busy,
	output logic                sin_neg,
	output logic [CS_MAG_W-1:0] sin_mag,
	output logic                cos_neg,
	output logic [CS_MAG_W-1:0] cos_mag
);
	logic                         busy_q;
	logic [CORDIC_IDX_W-1:0]      i_q;
	logic signed [CS_W-1:0]       x_q;
	logic signed [CS_W-1:0]       y_q;
	logic signed [CORDIC_Z_W-1:0] z_q;
	logic                         neg_q;
	logic signed [ANGLE_W+1:0]    z_red;
	logic                         neg_nxt;
	logic signed [CORDIC_Z_W-1:0] z_init;
	logic signed [CS_W-1:0]       dx;
	logic signed [CS_W-1:0]       dy;
	logic signed [CS_W-1:0]       x_abs;
	logic signed [CS_W-1:0]       y_abs;

	always_comb begin
		neg_nxt = 1'b0;
		if (angle > QUARTER_TURN && angle <= THREE_QUARTER_TURN) begin
			z_red   = $signed({2'b00, angle}) - $signed({2'b00, HALF_TURN});
			neg_nxt = 1'b1;
		end else if (angle > THREE_QUARTER_TURN) begin
			z_red = $signed({2'b00, angle}) - $signed({2'b00, FULL_TURN});
		end else begin
			z_red = $signed({2'b00, angle});
		end
		z_init = CORDIC_Z_W'(z_red) <<< ANGLE_FRAC;
	end

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
		end else if (busy_q) begin
			i_q <= i_q + CORDIC_IDX_W'(1);
			if (i_q == CORDIC_IDX_W'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= z_init;
			neg_q <= neg_nxt;
		end else if (busy_q) begin
			if (!z_q[CORDIC_Z_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ATAN_TAB[i_q];
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ATAN_TAB[i_q];
			end
		end
	end

	assign x_abs   = x_q[CS_W-1] ? -x_q : x_q;
	assign y_abs   = y_q[CS_W-1] ? -y_q : y_q;
	assign cos_mag = x_abs[CS_MAG_W-1:0];
	assign sin_mag = y_abs[CS_MAG_W-1:0];
	assign cos_neg = x_q[CS_W-1] ^ neg_q;
	assign sin_neg = y_q[CS_W-1] ^ neg_q;
	assign busy    = busy_q;
endmodule

// File: rtl/pvg_datapath.sv
// ----------------------------------------------------------------------------
// pvg_datapath
// Request registers, shared divider, CORDIC, scaling multipliers,
// digit-serial divide by 100, saturation and the output register.
// ----------------------------------------------------------------------------
module pvg_datapath import pvg_pkg::*; #(
	parameter int MAX_SIDES = 63,
	parameter int FRAC_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  pvg_req_t  req_payload,
	input  pvg_cmd_t  cmd,
	output pvg_stat_t stat,
	output logic      vtx_valid,
	output pvg_vtx_t  vtx_payload,
	input  logic      vtx_ready
);
	localparam int R_W   = BOX_W + FRAC_BITS - 1;
	localparam int PR_W  = R_W + CS_MAG_W;
	localparam int PY_W  = R_W + 2;
	localparam int PX_W  = PY_W + RATIO_W;
	localparam int N_W   = PX_W + 1;
	localparam int N2_W  = N_W - 2;
	localparam int ND    = (N2_W + DIGIT_W - 1) / DIGIT_W;
	localparam int DQ_W  = ND * DIGIT_W;
	localparam int DC_W  = $clog2(ND + 1);
	localparam int SAT_W = DQ_W;
	localparam logic [PR_W:0] Q30_HALF = (PR_W + 1)'(1) << (Q30_SHIFT - 1);

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic neg,
			input logic [SAT_W-1:0] mag);
		logic signed [COORD_W-1:0] res;
		if (mag > SAT_W'(COORD_POS_LIM)) begin
			res = neg ? COORD_MIN_V : COORD_MAX_V;
		end else begin
			res = neg ? -$signed(mag[COORD_W-1:0]) : $signed(mag[COORD_W-1:0]);
		end
		return res;
	endfunction

	// request state
	logic [SIDES_W-1:0]    n_q;
	logic                  hzero_q;
	logic [R_W-1:0]        r_q;
	logic [COORD_W-1:0]    start_y_q;
	logic [RATIO_W-1:0]    ratio_q;
	logic [ANGLE_W-1:0]    step_q;
	logic [ANGLE_W-1:0]    angle_q;
	logic [SIDES_W-1:0]    vcount_q;
	// per-vertex arithmetic
	logic [PR_W-1:0]       prod_c_q;
	logic [PR_W-1:0]       prod_s_q;
	logic                  ysign_q;
	logic                  xsign_q;
	logic [PY_W-1:0]       py_q;
	logic [PY_W-1:0]       ps_q;
	logic [PX_W-1:0]       px_q;
	logic [DQ_W-1:0]       sh_q;
	logic [DREM_W-1:0]     drem_q;
	logic [DC_W-1:0]       dcnt_q;
	// output register
	logic                  vtx_valid_q;
	pvg_vtx_t              vtx_q;

	logic [SIDES_W-1:0]    n_clamp;
	logic [R_W-1:0]        r_nxt;
	logic                  div_start;
	logic [DIV_NUM_W-1:0]  div_num;
	logic [DIV_DEN_W-1:0]  div_den;
	logic                  div_busy;
	logic [DIV_NUM_W-1:0]  div_quo;
	logic [ANGLE_W-1:0]    angle_nxt;
	logic                  rot_busy;
	logic                  sin_neg;
	logic [CS_MAG_W-1:0]   sin_mag;
	logic                  cos_neg;
	logic [CS_MAG_W-1:0]   cos_mag;
	logic [PR_W:0]         rnd_c;
	logic [PR_W:0]         rnd_s;
	logic [N_W-1:0]        n_sum;
	logic [DCUR_W-1:0]     dcur;
	logic [DPROD_W-1:0]    dprod;
	logic [DIGIT_W-1:0]    qdig;
	logic [DCUR_W-1:0]     dsub;
	logic                  out_free;

	always_comb begin
		if (req_payload.sides == '0) begin
			n_clamp = SIDES_W'(1);
		end else if (req_payload.sides > SIDES_W'(MAX_SIDES)) begin
			n_clamp = SIDES_W'(MAX_SIDES);
		end else begin
			n_clamp = req_payload.sides;
		end
	end

	assign r_nxt = {req_payload.box_height, {(FRAC_BITS - 1){1'b0}}};

	assign div_start = cmd.accept | cmd.ratio_take;
	assign div_num   = cmd.accept ? DIV_NUM_W'(req_payload.box_width * RATIO_SCALE)
	                              : DIV_NUM_W'(FULL_TURN);
	assign div_den   = cmd.accept ? req_payload.box_height : DIV_DEN_W'(n_q);

	pvg_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign angle_nxt = angle_q + step_q;

	pvg_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.angle_adv),
		.angle   (angle_nxt),
		.busy    (rot_busy),
		.sin_neg (sin_neg),
		.sin_mag (sin_mag),
		.cos_neg (cos_neg),
		.cos_mag (cos_mag)
	);

	assign rnd_c = {1'b0, prod_c_q} + Q30_HALF;
	assign rnd_s = {1'b0, prod_s_q} + Q30_HALF;
	assign n_sum = {1'b0, px_q} + N_W'(RATIO_HALF);

	// one base-256 digit of the divide by 25 per cycle
	assign dcur  = {drem_q, sh_q[DQ_W-1 -: DIGIT_W]};
	assign dprod = DPROD_W'(dcur) * DPROD_W'(RECIP_25);
	assign qdig  = DIGIT_W'(dprod >> RECIP_SHIFT);
	assign dsub  = dcur - DCUR_W'(DCUR_W'(qdig) * DCUR_W'(DIV25));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			n_q       <= n_clamp;
			hzero_q   <= (req_payload.box_height == '0);
			r_q       <= r_nxt;
			start_y_q <= sat_coord(1'b0, SAT_W'(r_nxt));
			angle_q   <= '0;
			vcount_q  <= '0;
		end
		if (cmd.ratio_take) begin
			ratio_q <= hzero_q ? '0 : div_quo;
		end
		if (cmd.step_take) begin
			step_q <= div_quo[ANGLE_W-1:0];
		end
		if (cmd.angle_adv) begin
			angle_q  <= angle_nxt;
			vcount_q <= vcount_q + SIDES_W'(1);
		end
		if (cmd.mul_r) begin
			prod_c_q <= PR_W'(r_q) * PR_W'(cos_mag);
			prod_s_q <= PR_W'(r_q) * PR_W'(sin_mag);
			ysign_q  <= cos_neg;
			xsign_q  <= sin_neg;
		end
		if (cmd.round_q30) begin
			py_q <= rnd_c[PR_W:Q30_SHIFT];
			ps_q <= rnd_s[PR_W:Q30_SHIFT];
		end
		if (cmd.mul_a) begin
			px_q <= PX_W'(ps_q) * PX_W'(ratio_q);
		end
		if (cmd.d100_load) begin
			sh_q   <= DQ_W'(n_sum[N_W-1:2]);
			drem_q <= '0;
		end else if (stat.d100_busy) begin
			sh_q   <= {sh_q[DQ_W-DIGIT_W-1:0], qdig};
			drem_q <= dsub[DREM_W-1:0];
		end
		case (cmd.emit)
			EMIT_START: begin
				vtx_q.x_pos <= '0;
				vtx_q.y_pos <= start_y_q;
				vtx_q.last  <= 1'b0;
			end
			EMIT_VTX: begin
				vtx_q.x_pos <= sat_coord(xsign_q, sh_q);
				vtx_q.y_pos <= sat_coord(ysign_q, SAT_W'(py_q));
				vtx_q.last  <= 1'b0;
			end
			EMIT_LAST: begin
				vtx_q.x_pos <= '0;
				vtx_q.y_pos <= start_y_q;
				vtx_q.last  <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q      <= '0;
			vtx_valid_q <= 1'b0;
		end else begin
			if (cmd.d100_load) begin
				dcnt_q <= DC_W'(ND);
			end else if (dcnt_q != '0) begin
				dcnt_q <= dcnt_q - DC_W'(1);
			end
			if (cmd.emit != EMIT_NONE) begin
				vtx_valid_q <= 1'b1;
			end else if (vtx_ready) begin
				vtx_valid_q <= 1'b0;
			end
		end
	end

	assign out_free = !vtx_valid_q || vtx_ready;

	assign stat.div_busy  = div_busy;
	assign stat.rot_busy  = rot_busy;
	assign stat.d100_busy = (dcnt_q != '0);
	assign stat.out_free  = out_free;
	assign stat.more      = (vcount_q != (n_q - SIDES_W'(1)));

	assign vtx_valid   = vtx_valid_q;
	assign vtx_payload = vtx_q;

`ifndef SYNTHESIS
	a_div_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> stat.div_busy)
		else $error("divider not busy after request transaction");
	a_last_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit == EMIT_LAST) |=> (vtx_valid_q && vtx_q.last))
		else $error("closing vertex not presented");
	a_last_on_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(vtx_valid_q && vtx_q.last) |-> (vtx_q.x_pos == '0))
		else $error("closing vertex off the axis");
`endif
endmodule

// File: rtl/pvg_controller.sv
// ----------------------------------------------------------------------------
// pvg_controller
// Sequencer: setup divisions, then per vertex angle step, CORDIC, scaling,
// divide by 100 and output load; start and closing points around them.
// ----------------------------------------------------------------------------
module pvg_controller import pvg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  pvg_stat_t stat,
	output pvg_cmd_t  cmd
);
	typedef enum logic [12:0] {
		ST_IDLE      = 13'h0001,
		ST_DIV_RATIO = 13'h0002,
		ST_DIV_STEP  = 13'h0004,
		ST_EMIT_ST   = 13'h0008,
		ST_ANGLE     = 13'h0010,
		ST_ROT       = 13'h0020,
		ST_MUL_R     = 13'h0040,
		ST_ROUND     = 13'h0080,
		ST_MUL_A     = 13'h0100,
		ST_D100_LD   = 13'h0200,
		ST_D100      = 13'h0400,
		ST_EMIT_VTX  = 13'h0800,
		ST_EMIT_LAST = 13'h1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		cmd.emit  = EMIT_NONE;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_DIV_RATIO;
				end
			end
			ST_DIV_RATIO: begin
				if (!stat.div_busy) begin
					cmd.ratio_take = 1'b1;
					state_nxt      = ST_DIV_STEP;
				end
			end
			ST_DIV_STEP: begin
				if (!stat.div_busy) begin
					cmd.step_take = 1'b1;
					state_nxt     = ST_EMIT_ST;
				end
			end
			ST_EMIT_ST: begin
				if (stat.out_free) begin
					cmd.emit  = EMIT_START;
					state_nxt = stat.more ? ST_ANGLE : ST_EMIT_LAST;
				end
			end
			ST_ANGLE: begin
				cmd.angle_adv = 1'b1;
				state_nxt     = ST_ROT;
			end
			ST_ROT: begin
				if (!stat.rot_busy) begin
					state_nxt = ST_MUL_R;
				end
			end
			ST_MUL_R: begin
				cmd.mul_r = 1'b1;
				state_nxt = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_q30 = 1'b1;
				state_nxt     = ST_MUL_A;
			end
			ST_MUL_A: begin
				cmd.mul_a = 1'b1;
				state_nxt = ST_D100_LD;
			end
			ST_D100_LD: begin
				cmd.d100_load = 1'b1;
				state_nxt     = ST_D100;
			end
			ST_D100: begin
				if (!stat.d100_busy) begin
					state_nxt = ST_EMIT_VTX;
				end
			end
			ST_EMIT_VTX: begin
				if (stat.out_free) begin
					cmd.emit  = EMIT_VTX;
					state_nxt = stat.more ? ST_ANGLE : ST_EMIT_LAST;
				end
			end
			ST_EMIT_LAST: begin
				if (stat.out_free) begin
					cmd.emit  = EMIT_LAST;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign req_ready = (state_q == ST_IDLE);

`ifndef SYNTHESIS
	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(stat.div_busy || stat.rot_busy || stat.d100_busy))
		else $error("arithmetic unit busy while idle");
	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit != EMIT_NONE) |-> stat.out_free)
		else $error("output register overwritten");
`endif
endmodule

// File: rtl/polygon_vertex_generator.sv
// ----------------------------------------------------------------------------
// polygon_vertex_generator
// Regular polygon vertices inscribed in the ellipse of a bounding box.
//
// Each request transaction (box_width, box_height, sides) produces sides+1
// vertex transactions: the start point (0, h/2), one vertex per angle step
// running clockwise, and the closing point (0, h/2) with last set. Sides of
// zero count as one, sides above MAX_SIDES as MAX_SIDES. Coordinates are
// signed with FRAC_BITS fraction bits, saturated to 24 bits. One request is
// processed at a time. The setup uses the restoring divider (one quotient
// bit per cycle, two divisions), each vertex the CORDIC (one micro-rotation
// per cycle, 16 steps) and the digit-serial divide by 100. A finished
// vertex waits in the output register while the next one is computed.
// ----------------------------------------------------------------------------
module polygon_vertex_generator import pvg_pkg::*; #(
	parameter int MAX_SIDES = 63,
	parameter int FRAC_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	pvg_stream_if.sink   req,
	pvg_stream_if.source vtx
);
	pvg_cmd_t  cmd;
	pvg_stat_t stat;
	pvg_vtx_t  vtx_payload;
	logic      vtx_valid;
	logic      req_ready;

	pvg_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pvg_datapath #(
		.MAX_SIDES (MAX_SIDES),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_payload (req.payload),
		.cmd         (cmd),
		.stat        (stat),
		.vtx_valid   (vtx_valid),
		.vtx_payload (vtx_payload),
		.vtx_ready   (vtx.ready)
	);

	assign req.ready   = req_ready;
	assign vtx.valid   = vtx_valid;
	assign vtx.payload = vtx_payload;
endmodule

// File: tb/sv/pvg_vertex_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvg_vertex_checker
// Watches the request and vertex channels of the polygon vertex generator.
// Each accepted request is expanded into the full vertex list (start point,
// CORDIC-stepped vertices, closing point) and every accepted vertex is
// compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pvg_vertex_checker import pvg_pkg::*; #(
	parameter int MAX_SIDES = 63,
	parameter int FRAC_BITS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_ready,
	input  pvg_req_t req_payload,
	input  logic     vtx_valid,
	input  logic     vtx_ready,
	input  pvg_vtx_t vtx_payload,
	output int       fail_count,
	output int       open_vertices,
	output int       polygons_seen,
	output int       vertices_seen
);

	localparam longint ANG_90  = 9000;
	localparam longint ANG_180 = 18000;
	localparam longint ANG_270 = 27000;
	localparam longint ANG_360 = 36000;
	localparam longint ROT_GAIN = 652032874;
	localparam longint COORD_HI = 8388607;
	localparam longint COORD_LO = -8388608;
	localparam longint ARCTAN_Q [16] = '{
		1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
		5730, 2865, 1432, 716, 358, 179, 90, 45
	};

	pvg_vtx_t vertex_q [$];
	int       fails = 0;
	int       polygons = 0;
	int       vertices = 0;

	function automatic logic signed [COORD_W-1:0] clip_coord(longint v);
		if (v > COORD_HI)
			return COORD_HI[COORD_W-1:0];
		if (v < COORD_LO)
			return COORD_LO[COORD_W-1:0];
		return v[COORD_W-1:0];
	endfunction

	// r * v / 2^30, rounded on the magnitude
	function automatic longint round_q30(longint unsigned r, longint v);
		longint unsigned m;
		longint unsigned p;
		m = (v < 0) ? -v : v;
		p = (r * m + (64'd1 << 29)) >> 30;
		return (v < 0) ? -longint'(p) : longint'(p);
	endfunction

	function automatic void predict_polygon(pvg_req_t rq);
		int unsigned     w, h, n, ratio, step, ang;
		longint unsigned r, m;
		longint          cx, cy, cz, dx, dy, sn, cs, xv, yv;
		logic            flip;
		pvg_vtx_t        v;
		logic signed [COORD_W-1:0] start_y;
		w = rq.box_width;
		h = rq.box_height;
		n = (rq.sides == 0) ? 1 : rq.sides;
		if (n > MAX_SIDES)
			n = MAX_SIDES;
		ratio = (h == 0) ? 0 : (w * 100) / h;
		step = 32'(ANG_360 / n);
		ang = 0;
		r = longint'(h) << (FRAC_BITS - 1);
		start_y = clip_coord(longint'(r));

		v.x_pos = '0;
		v.y_pos = start_y;
		v.last = 1'b0;
		vertex_q.push_back(v);

		for (int unsigned k = 1; k < n; k++) begin
			ang = (ang + step) & 32'hFFFF;
			flip = 1'b0;
			if (ang > ANG_90 && ang <= ANG_270) begin
				cz = longint'(ang) - ANG_180;
				flip = 1'b1;
			end else if (ang > ANG_270) begin
				cz = longint'(ang) - ANG_360;
			end else begin
				cz = longint'(ang);
			end
			cz = cz * 256;
			cx = ROT_GAIN;
			cy = 0;
			for (int i = 0; i < 16; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cz >= 0) begin
					cx = cx - dx;
					cy = cy + dy;
					cz = cz - ARCTAN_Q[i];
				end else begin
					cx = cx + dx;
					cy = cy - dy;
					cz = cz + ARCTAN_Q[i];
				end
			end
			sn = flip ? -cy : cy;
			cs = flip ? -cx : cx;
			yv = round_q30(r, cs);
			xv = round_q30(r, sn);
			m = (xv < 0) ? -xv : xv;
			m = (m * ratio + 50) / 100;
			xv = (xv < 0) ? -longint'(m) : longint'(m);
			v.x_pos = clip_coord(xv);
			v.y_pos = clip_coord(yv);
			v.last = 1'b0;
			vertex_q.push_back(v);
		end

		v.x_pos = '0;
		v.y_pos = start_y;
		v.last = 1'b1;
		vertex_q.push_back(v);
	endfunction

	function automatic void flag_field(string name, longint want, longint got);
		fails++;
		$error("%s: expected %0d, got %0d", name, want, got);
	endfunction

	always @(posedge clk) begin
		pvg_vtx_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				predict_polygon(req_payload);
				polygons++;
			end
			if (vtx_valid && vtx_ready) begin
				vertices++;
				if (vertex_q.size() == 0) begin
					fails++;
					$error("vertex transaction with nothing outstanding: x %0d y %0d last %0b",
						$signed(vtx_payload.x_pos), $signed(vtx_payload.y_pos),
						vtx_payload.last);
				end else begin
					want = vertex_q.pop_front();
					if (vtx_payload.x_pos !== want.x_pos)
						flag_field("x_pos", $signed(want.x_pos), $signed(vtx_payload.x_pos));
					if (vtx_payload.y_pos !== want.y_pos)
						flag_field("y_pos", $signed(want.y_pos), $signed(vtx_payload.y_pos));
					if (vtx_payload.last !== want.last)
						flag_field("last", want.last, vtx_payload.last);
				end
			end
		end
		fail_count    <= fails;
		open_vertices <= vertex_q.size();
		polygons_seen <= polygons;
		vertices_seen <= vertices;
	end

endmodule

// File: tb/sv/polygon_vertex_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_vertex_generator_tb
// Drives polygon requests into the vertex generator: a directed set of box
// and side-count corners, then random requests sent in bursts against a
// stalling vertex sink. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module polygon_vertex_generator_tb;
	import pvg_pkg::*;

	localparam int MAX_SIDES  = 63;
	localparam int FRAC_BITS  = 8;
	localparam int RAND_ITEMS = 250;
	localparam int N_CORNERS  = 17;

	localparam pvg_req_t CORNER_REQS [N_CORNERS] = '{
		'{16'd1,     16'd1,     6'd1},
		'{16'd65535, 16'd65535, 6'd63},
		'{16'd65535, 16'd1,     6'd4},
		'{16'd1,     16'd65535, 6'd4},
		'{16'd500,   16'd0,     6'd6},
		'{16'd300,   16'd200,   6'd0},
		'{16'd100,   16'd100,   6'd2},
		'{16'd1000,  16'd1000,  6'd3},
		'{16'd2000,  16'd1000,  6'd4},
		'{16'd999,   16'd1000,  6'd8},
		'{16'd1234,  16'd4321,  6'd12},
		'{16'd40000, 16'd20000, 6'd36},
		'{16'd65535, 16'd65535, 6'd32},
		'{16'd3,     16'd7,     6'd5},
		'{16'd65535, 16'd2,     6'd63},
		'{16'd2,     16'd65535, 6'd63},
		'{16'd12345, 16'd54321, 6'd7}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic steady = 1'b0;
	int   stall_left = 0;
	int   fail_count, open_vertices, polygons_seen, vertices_seen;

	pvg_stream_if #(.payload_t(pvg_req_t)) req_ch();
	pvg_stream_if #(.payload_t(pvg_vtx_t)) vtx_ch();

	polygon_vertex_generator #(
		.MAX_SIDES(MAX_SIDES),
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.vtx   (vtx_ch)
	);

	pvg_vertex_checker #(
		.MAX_SIDES(MAX_SIDES),
		.FRAC_BITS(FRAC_BITS)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_ch.valid),
		.req_ready    (req_ch.ready),
		.req_payload  (req_ch.payload),
		.vtx_valid    (vtx_ch.valid),
		.vtx_ready    (vtx_ch.ready),
		.vtx_payload  (vtx_ch.payload),
		.fail_count   (fail_count),
		.open_vertices(open_vertices),
		.polygons_seen(polygons_seen),
		.vertices_seen(vertices_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// vertex sink: random stalls, no new ones started while steady
	always @(posedge clk) begin
		if (stall_left != 0) begin
			vtx_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!steady && $urandom_range(0, 3) == 0) begin
			vtx_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			vtx_ch.ready <= 1'b1;
		end
	end

	task automatic send_request(input pvg_req_t rq);
		req_ch.valid <= 1'b1;
		req_ch.payload <= rq;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		if (cycles != 0) begin
			req_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic settle_all();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (open_vertices != 0);
	endtask

	initial begin
		#40000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		pvg_req_t    rq;
		int unsigned burst_left;
		int unsigned shape, pick;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_CORNERS; i++)
			send_request(CORNER_REQS[i]);
		settle_all();

		burst_left = 0;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == 60)
				steady <= 1'b1;
			if (i == 120) begin
				steady <= 1'b0;
				settle_all();
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 8);
				if (!steady)
					pause_sender(($urandom_range(0, 3) == 0) ?
						$urandom_range(10, 40) : $urandom_range(0, 6));
			end
			burst_left--;

			shape = $urandom_range(0, 3);
			rq.box_height = 16'($urandom_range(1, (shape == 1) ? 64 : 65535));
			case (shape)
				2: rq.box_width = rq.box_height + 16'($urandom_range(0, 3));
				3: rq.box_width = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
				default: rq.box_width = 16'($urandom_range(1, (shape == 1) ? 64 : 65535));
			endcase
			if (rq.box_width == 0)
				rq.box_width = 16'd1;
			if ($urandom_range(0, 49) == 0)
				rq.box_height = '0;
			pick = $urandom_range(0, 99);
			if (pick < 3)
				rq.sides = '0;
			else if (pick < 80)
				rq.sides = 6'($urandom_range(1, 15));
			else
				rq.sides = 6'($urandom_range(16, 63));
			send_request(rq);
		end
		settle_all();
		repeat (64) @(posedge clk);

		$display("Run covered %0d polygons and %0d vertex transactions,",
			polygons_seen, vertices_seen);
		$display("including degenerate boxes and side counts, with and without back-pressure.");
		if (fail_count == 0 && open_vertices == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: polygon_vertex_generator.f
rtl/pvg_pkg.sv
rtl/pvg_stream_if.sv
rtl/pvg_divider.sv
rtl/pvg_cordic.sv
rtl/pvg_datapath.sv
rtl/pvg_controller.sv
rtl/polygon_vertex_generator.sv
tb/sv/pvg_vertex_checker.sv
tb/sv/polygon_vertex_generator_tb.sv
